// ===== sv/ptt_pkg.sv =====
// Shared types, codes and constants of the periodic timer table.
package ptt_pkg;

	localparam int NUM_SLOTS_DEF = 64;
	localparam int TICK_MS_DEF   = 10;
	localparam int MAX_RESULTS   = 64;
	localparam int CMD_W         = 3;
	localparam int SLOT_W        = 6;
	localparam int IV_W          = 16;
	localparam int KIND_W        = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;

	localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIRE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
		logic [IV_W-1:0]   interval_ms;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot_out;
		logic              ok;
		logic              last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_DIV,
		ST_TICK,
		ST_END
	} state_t;

endpackage

// ===== sv/periodic_timer_table.sv =====
// Top level: sequencer, slot flags and period/count memories of the timer table.
//
//   channel  direction  payload  handshake
//   req      in         req_t    req_valid / req_stall
//   rsp      out        rsp_t    rsp_valid / rsp_stall
//
// Start, stop, destroy and unknown commands pass the decode and end states to their acknowledge.
// Allocate and set interval add the divider wait state for the multiply by the reciprocal of TICK_MS.
// A tick walks each used slot through the period/count memory read, which sets the pace.
// A stalled result holds the tick walk only when a second fire is waiting.
// Reset clears the flags and slot counter at once; memories need no clearing pass.
module periodic_timer_table #(
	parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
	parameter int TICK_MS   = ptt_pkg::TICK_MS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ptt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ptt_pkg::rsp_t rsp
);

	import ptt_pkg::*;

	localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
	localparam int UW    = $clog2(NUM_SLOTS + 1);
	localparam int CW    = (SLOT_W > IDX_W ? SLOT_W : IDX_W) + 1;
	localparam int PER_W = $clog2(65535 / TICK_MS + 1);
	localparam int FW    = $clog2(MAX_RESULTS + 1);

	state_t state_q, state_d;

	req_t             req_q;
	logic [UW-1:0]    used_q;
	logic             valid_q  [NUM_SLOTS];
	logic             active_q [NUM_SLOTS];
	rsp_t             pend_q;
	logic             pend_vld_q;
	rsp_t             rsp_q;
	logic             rsp_vld_q;
	logic [UW-1:0]    rd_idx_q;
	logic [FW-1:0]    nfire_q;
	logic             p_vld_s1;
	logic [IDX_W-1:0] p_idx_s1;

	logic [CW-1:0]    slot_ext;
	logic [IDX_W-1:0] slot_idx;
	logic [IDX_W-1:0] tgt_idx;
	logic             good;
	logic             full;
	logic             out_free;
	logic             is_alloc;

	logic             div_start;
	logic             div_done;
	logic [PER_W-1:0] div_period;

	logic             per_we;
	logic [PER_W-1:0] per_rd;
	logic             cnt_we;
	logic [IDX_W-1:0] cnt_waddr;
	logic [PER_W-1:0] cnt_wdata;
	logic [PER_W-1:0] cnt_rd;
	logic             rd_en;

	logic             en;
	logic [PER_W:0]   sum;
	logic             fire;
	logic             report;
	logic             hold;
	logic             issue;

	logic             push;
	rsp_t             push_rsp;
	logic             pend_ld;
	rsp_t             pend_d;
	logic             pend_clr;
	logic             val_we;
	logic             val_wd;
	logic             act_we;
	logic             act_wd;
	logic             used_inc;
	logic             tick_init;
	logic             nfire_inc;

	assign slot_ext = CW'(req_q.slot);
	assign slot_idx = slot_ext[IDX_W-1:0];
	assign good     = (slot_ext < CW'(NUM_SLOTS)) && valid_q[slot_idx];
	assign full     = used_q >= UW'(NUM_SLOTS);
	assign out_free = !rsp_vld_q || !rsp_stall;
	assign is_alloc = req_q.cmd == CMD_ALLOC;
	assign tgt_idx  = is_alloc ? used_q[IDX_W-1:0] : slot_idx;

	assign en     = p_vld_s1 && valid_q[p_idx_s1] && active_q[p_idx_s1] && per_rd != '0;
	assign sum    = {1'b0, cnt_rd} + 1'b1;
	assign fire   = en && (sum >= {1'b0, per_rd});
	assign report = fire && (nfire_q < FW'(MAX_RESULTS));
	assign hold   = report && pend_vld_q && !out_free;
	assign issue  = !hold && (rd_idx_q < used_q);

	ptt_div #(
		.TICK_MS (TICK_MS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req_q.interval_ms),
		.done     (div_done),
		.period   (div_period)
	);

	ptt_ram #(
		.WIDTH (PER_W),
		.DEPTH (NUM_SLOTS)
	) u_period_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (tgt_idx),
		.wdata (div_period),
		.re    (rd_en),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (per_rd)
	);

	ptt_ram #(
		.WIDTH (PER_W),
		.DEPTH (NUM_SLOTS)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		push_rsp  = pend_q;
		pend_ld   = 1'b0;
		pend_d    = '{kind: KIND_ACK, slot_out: req_q.slot, ok: good, last: 1'b0};
		pend_clr  = 1'b0;
		val_we    = 1'b0;
		val_wd    = 1'b0;
		act_we    = 1'b0;
		act_wd    = 1'b0;
		used_inc  = 1'b0;
		div_start = 1'b0;
		per_we    = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = tgt_idx;
		cnt_wdata = '0;
		rd_en     = 1'b0;
		tick_init = 1'b0;
		nfire_inc = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_CMD;
				end
			end
			ST_CMD: begin
				pend_ld = 1'b1;
				state_d = ST_END;
				case (req_q.cmd)
					CMD_ALLOC: begin
						if (full) begin
							pend_d = '{kind: KIND_ACK, slot_out: '0, ok: 1'b0, last: 1'b0};
						end else begin
							pend_ld   = 1'b0;
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
					CMD_START: begin
						act_we = good;
						act_wd = 1'b1;
					end
					CMD_STOP: begin
						act_we = good;
						cnt_we = good;
					end
					CMD_SET: begin
						if (good) begin
							pend_ld   = 1'b0;
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
					CMD_DESTROY: begin
						val_we = good;
						act_we = good;
					end
					CMD_TICK: begin
						pend_ld   = 1'b0;
						tick_init = 1'b1;
						state_d   = ST_TICK;
					end
					default: begin
						pend_d.ok = 1'b0;
					end
				endcase
			end
			ST_DIV: begin
				if (div_done) begin
					per_we  = 1'b1;
					cnt_we  = 1'b1;
					act_we  = 1'b1;
					act_wd  = !is_alloc;
					val_we  = is_alloc;
					val_wd  = 1'b1;
					used_inc = is_alloc;
					pend_ld = 1'b1;
					pend_d  = '{kind: KIND_ACK,
						slot_out: is_alloc ? SLOT_W'(used_q) : req_q.slot,
						ok: 1'b1, last: 1'b0};
					state_d = ST_END;
				end
			end
			ST_TICK: begin
				cnt_waddr = p_idx_s1;
				cnt_wdata = fire ? '0 : sum[PER_W-1:0];
				if (!hold) begin
					cnt_we = en;
					if (report) begin
						pend_ld   = 1'b1;
						pend_d    = '{kind: KIND_FIRE, slot_out: SLOT_W'(p_idx_s1),
							ok: 1'b1, last: 1'b0};
						nfire_inc = 1'b1;
						push      = pend_vld_q;
					end
				end
				rd_en = issue;
				if (!hold && !issue) begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				if (out_free) begin
					push     = 1'b1;
					push_rsp = pend_vld_q
						? '{kind: pend_q.kind, slot_out: pend_q.slot_out, ok: pend_q.ok,
							last: 1'b1}
						: '{kind: KIND_NONE, slot_out: '0, ok: 1'b1, last: 1'b1};
					pend_clr = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			pend_vld_q <= 1'b0;
			rsp_vld_q  <= 1'b0;
			rd_idx_q   <= '0;
			nfire_q    <= '0;
			p_vld_s1   <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				valid_q[i]  <= 1'b0;
				active_q[i] <= 1'b0;
			end
		end else begin
			if (used_inc) begin
				used_q <= used_q + 1'b1;
			end
			if (val_we) begin
				valid_q[tgt_idx] <= val_wd;
			end
			if (act_we) begin
				active_q[tgt_idx] <= act_wd;
			end
			if (pend_ld) begin
				pend_vld_q <= 1'b1;
			end else if (pend_clr) begin
				pend_vld_q <= 1'b0;
			end
			if (push) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
			if (tick_init) begin
				rd_idx_q <= '0;
				nfire_q  <= '0;
				p_vld_s1 <= 1'b0;
			end else if (state_q == ST_TICK) begin
				if (nfire_inc) begin
					nfire_q <= nfire_q + 1'b1;
				end
				if (!hold) begin
					p_vld_s1 <= issue;
				end
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q <= req;
		end
		if (pend_ld) begin
			pend_q <= pend_d;
		end
		if (push) begin
			rsp_q <= push_rsp;
		end
		if (issue && state_q == ST_TICK) begin
			p_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(NUM_SLOTS))
		else $error("slot counter beyond table size");

	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfire_q <= FW'(MAX_RESULTS))
		else $error("too many fires reported in one tick");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its wait state");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> state_q == ST_CMD)
		else $error("accepted command not decoded");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed over an untaken transfer");

endmodule

// ===== sv/ptt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module ptt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/ptt_div.sv =====
// Reciprocal multiply by the tick length that turns an interval into a period.
module ptt_div #(
	parameter int TICK_MS = ptt_pkg::TICK_MS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              start,
	input  logic [ptt_pkg::IV_W-1:0]                          dividend,
	output logic                                              done,
	output logic [$clog2(65535 / TICK_MS + 1)-1:0]            period
);

	import ptt_pkg::*;

	localparam int     PER_W   = $clog2(65535 / TICK_MS + 1);
	localparam int     SH      = $clog2(TICK_MS);
	localparam int     MW      = IV_W + 1;
	localparam int     PW      = IV_W + MW;
	localparam longint MAGIC_L = ((longint'(1) << (IV_W + SH)) + longint'(TICK_MS) - 1) /
		longint'(TICK_MS);
	localparam logic [MW-1:0] MAGIC = MW'(MAGIC_L);

	logic             done_q;
	logic [PER_W-1:0] period_q;

	logic [PW-1:0]    prod;
	logic [IV_W-1:0]  quot;

	always_comb begin
		prod = PW'(dividend) * PW'(MAGIC);
		quot = IV_W'(prod >> (IV_W + SH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// short interval counts as one tick
			period_q <= (quot == '0 && dividend != '0) ? PER_W'(1) : PER_W'(quot);
		end
	end

	assign done   = done_q;
	assign period = period_q;

endmodule
